// ===== design/dual_tone_cadence_generator_assert.svh =====
// assertion macros for the dual tone cadence generator
// expects clk and rst_n in the scope of the module that uses them
`ifndef DUAL_TONE_CADENCE_GENERATOR_ASSERT_SVH
`define DUAL_TONE_CADENCE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define DTCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtcg assertion failed");

// next-cycle implication
`define DTCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtcg assertion failed");

`endif

// ===== design/dtcg_pkg.sv =====
// shared types and constants of the dual tone cadence generator
// no dependencies
`default_nettype none

package dtcg_pkg;

  localparam int DEF_MAX_ITEMS      = 16;
  localparam int DEF_SAMPLES_PER_MS = 8;

  localparam int COEF_W     = 18;
  localparam int START_W    = 16;
  localparam int OSC_W      = 18;
  localparam int SMP_W      = 16;
  localparam int DUR_W      = 16;
  localparam int IDX_IN_W   = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;

  // q15 resonator scaling
  localparam int SHIFT_Q    = 15;
  // shared multiplier operand and product widths
  localparam int MUL_XW     = 19;
  localparam int MUL_YW     = 25;
  localparam int PROD_W     = 44;
  // 0.9 gain as a reciprocal multiply, exact floor for magnitudes below 2^18
  localparam int MAG_W       = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_K     = ((1 << RECIP_SHIFT) + 9) / 10;
  localparam int MOD_GAIN_Q  = 9 * RECIP_K;
  localparam int MOD_OFFSET  = 32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_POS = 1'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_a;
    logic signed [START_W-1:0] a_prev;
    logic signed [START_W-1:0] a_cur;
    logic signed [COEF_W-1:0]  coef_b;
    logic signed [START_W-1:0] b_prev;
    logic signed [START_W-1:0] b_cur;
    logic                      mode;
    logic [DUR_W-1:0]          dur;
  } item_t;

  // datapath step strobes, one per computing sequencer state, plus the start-value reload
  typedef struct packed {
    logic mul_a;
    logic load_start;
    logic mul_b;
    logic upd_b;
    logic mul_mag;
    logic mul_mod;
  } dp_ctl_t;

  function automatic int idx_width(input int n);
    idx_width = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== design/dtcg_in_if.sv =====
// input channel of the dual tone cadence generator: command beats
// depends on dtcg_pkg
`default_nettype none

interface dtcg_in_if import dtcg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [IDX_IN_W-1:0]       item_index;
  logic signed [COEF_W-1:0]  osc_a_coef;
  logic signed [START_W-1:0] osc_a_start_prev;
  logic signed [START_W-1:0] osc_a_start_cur;
  logic signed [COEF_W-1:0]  osc_b_coef;
  logic signed [START_W-1:0] osc_b_start_prev;
  logic signed [START_W-1:0] osc_b_start_cur;
  logic                      modulate_mode;
  logic [DUR_W-1:0]          duration_ms;

  modport source (
    output valid, cmd, item_index, osc_a_coef, osc_a_start_prev, osc_a_start_cur,
           osc_b_coef, osc_b_start_prev, osc_b_start_cur, modulate_mode, duration_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, item_index, osc_a_coef, osc_a_start_prev, osc_a_start_cur,
           osc_b_coef, osc_b_start_prev, osc_b_start_cur, modulate_mode, duration_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/dtcg_out_if.sv =====
// result channel of the dual tone cadence generator: sample beats
// depends on dtcg_pkg
`default_nettype none

interface dtcg_out_if import dtcg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic [IDX_IN_W-1:0]     playing_item;
  logic                    stopped;

  modport source (output valid, sample, playing_item, stopped, input ready);
  modport sink (input valid, sample, playing_item, stopped, output ready);
endinterface

`default_nettype wire

// ===== design/dtcg_item_mem.sv =====
// tone item store: one write port, one registered read port
// depends on dtcg_pkg
`default_nettype none

module dtcg_item_mem import dtcg_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [idx_width(MAX_ITEMS)-1:0] waddr,
  input  item_t                           wdata,
  input  logic                            re,
  input  logic [idx_width(MAX_ITEMS)-1:0] raddr,
  output item_t                           rdata
);

  item_t mem [MAX_ITEMS];
  item_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/dtcg_voice.sv =====
// resonator pair datapath with one shared multiplier
// depends on dtcg_pkg; stepped by dp_ctl_t strobes from the top level
`default_nettype none

module dtcg_voice import dtcg_pkg::*; (
  input  logic                    clk,
  input  dp_ctl_t                 ctl,
  input  item_t                   entry,
  output logic signed [SMP_W-1:0] sample
);

  localparam int DW = OSC_W + 1;

  logic signed [OSC_W-1:0]  a_prev_r, a_prev_nxt, a_cur_r, a_cur_nxt;
  logic signed [OSC_W-1:0]  b_prev_r, b_prev_nxt, b_cur_r, b_cur_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;

  logic signed [OSC_W-1:0]  a_eff_prev, a_eff_cur, b_eff_prev, b_eff_cur;
  logic signed [OSC_W-1:0]  res_base, res_new;
  logic signed [DW-1:0]     off_d;
  logic [MAG_W-1:0]         gain;
  logic signed [MUL_XW-1:0] mx;
  logic signed [MUL_YW-1:0] my;

  always_comb begin
    // start values replace the running state on a reload
    a_eff_prev = ctl.load_start ? OSC_W'(entry.a_prev) : a_prev_r;
    a_eff_cur  = ctl.load_start ? OSC_W'(entry.a_cur)  : a_cur_r;
    b_eff_prev = ctl.load_start ? OSC_W'(entry.b_prev) : b_prev_r;
    b_eff_cur  = ctl.load_start ? OSC_W'(entry.b_cur)  : b_cur_r;

    // new cur = ((coef * cur) >>> 15) - prev, wrapped to the state width
    res_base = ctl.upd_b ? b_prev_r : a_prev_r;
    res_new  = $signed(prod_r[SHIFT_Q+OSC_W-1:SHIFT_Q]) - res_base;

    off_d   = DW'(res_new) - DW'(MOD_OFFSET);
    gain    = prod_r[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT] + MAG_W'(1);

    mx = '0;
    my = '0;
    if (ctl.mul_a) begin
      mx = MUL_XW'(a_eff_cur);
      my = MUL_YW'(entry.coef_a);
    end else if (ctl.mul_b) begin
      mx = MUL_XW'(b_cur_r);
      my = MUL_YW'(entry.coef_b);
    end else if (ctl.mul_mag) begin
      mx = $signed({1'b0, mag_r});
      my = MUL_YW'(MOD_GAIN_Q);
    end else if (ctl.mul_mod) begin
      mx = MUL_XW'(a_cur_r);
      my = MUL_YW'($signed({1'b0, gain}));
    end

    prod_nxt = prod_r;
    if (ctl.mul_a || ctl.mul_b || ctl.mul_mag || ctl.mul_mod) begin
      prod_nxt = PROD_W'(mx) * PROD_W'(my);
    end

    a_prev_nxt = a_prev_r;
    a_cur_nxt  = a_cur_r;
    b_prev_nxt = b_prev_r;
    b_cur_nxt  = b_cur_r;
    mag_nxt    = mag_r;
    if (ctl.mul_a) begin
      a_prev_nxt = a_eff_prev;
      a_cur_nxt  = a_eff_cur;
      b_prev_nxt = b_eff_prev;
      b_cur_nxt  = b_eff_cur;
    end
    if (ctl.mul_b) begin
      a_prev_nxt = a_cur_r;
      a_cur_nxt  = res_new;
    end
    if (ctl.upd_b) begin
      b_prev_nxt = b_cur_r;
      b_cur_nxt  = res_new;
      // |b - 32768|
      mag_nxt    = off_d[DW-1] ? MAG_W'(-off_d) : MAG_W'(off_d);
    end
  end

  always_ff @(posedge clk) begin
    a_prev_r <= a_prev_nxt;
    a_cur_r  <= a_cur_nxt;
    b_prev_r <= b_prev_nxt;
    b_cur_r  <= b_cur_nxt;
    prod_r   <= prod_nxt;
    mag_r    <= mag_nxt;
  end

  assign sample = entry.mode ? $signed(prod_r[SHIFT_Q+SMP_W-1:SHIFT_Q])
                             : a_cur_r[SMP_W-1:0] + b_cur_r[SMP_W-1:0];

endmodule

`default_nettype wire

// ===== design/dual_tone_cadence_generator.sv =====
// top level of the dual tone cadence generator: sequencer, playback state, result register
// depends on dtcg_pkg, dtcg_in_if, dtcg_out_if, dtcg_item_mem, dtcg_voice
`default_nettype none
`include "dual_tone_cadence_generator_assert.svh"

// Plays a list of tone items, one 16-bit sample per tick beat. Each item lives in an item
// memory with one write and one read port (coefficients, start values, mode, duration) and
// is read once per tick that is not halted; the two resonators run in registers and share a
// single 19x25 multiplier. A tick steps through memory read, product A, product B, update B
// and result in mix mode; in modulate mode the multiplier is used twice more, for the 0.9
// gain and the A times gain product, before the result. A tick while halted gives sample 0
// with stopped set. Load and restart beats and configuration writes give no result. The
// result sits in an output register, so load and restart beats are still taken while a
// sample waits downstream; a tick finishes only once that register is free. There is no
// clearing pass: an item that was never loaded plays undefined values.
module dual_tone_cadence_generator import dtcg_pkg::*; #(
  parameter int MAX_ITEMS      = DEF_MAX_ITEMS,
  parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dtcg_in_if.sink              in_chan,
  dtcg_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = idx_width(MAX_ITEMS);
  // wide enough for duration * samples per ms
  localparam int CNT_W = $clog2(((1 << DUR_W) - 1) * SAMPLES_PER_MS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MA   = 7'b0000010,
    S_MB   = 7'b0000100,
    S_MM   = 7'b0001000,
    S_MP   = 7'b0010000,
    S_MS   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        cur_item_r, cur_item_nxt;
  logic                    loaded_r, loaded_nxt;
  logic                    halted_r, halted_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CFG_W-1:0]        item_count_r;
  logic signed [CFG_W-1:0] repeat_pos_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_sample_r;
  logic [IDX_IN_W-1:0]     out_item_r;
  logic                    out_stopped_r;

  logic       in_acc, is_tick, is_load, is_restart, load_ok;
  logic       mem_re, mem_we, fin_go;
  item_t      wr_item, entry;
  dp_ctl_t    ctl;
  logic signed [SMP_W-1:0] voice_sample;

  // playback advance
  logic [IDX_W:0]   next_ext;
  logic             list_end, rp_bad;
  logic [IDX_W-1:0] new_item;
  logic [CNT_W-1:0] cnt_inc, thr;

  // ---------------------------------------------------------------- input decode
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_tick       = in_acc && (in_chan.cmd == CMD_TICK);
  assign is_load       = in_acc && (in_chan.cmd == CMD_LOAD);
  assign is_restart    = in_acc && (in_chan.cmd == CMD_RESTART);
  // loads beyond the list depth are dropped
  assign load_ok       = int'(in_chan.item_index) < MAX_ITEMS;

  assign mem_we = is_load && load_ok;
  // a halted tick needs no item data
  assign mem_re = is_tick && !halted_r;

  always_comb begin
    wr_item.coef_a = in_chan.osc_a_coef;
    wr_item.a_prev = in_chan.osc_a_start_prev;
    wr_item.a_cur  = in_chan.osc_a_start_cur;
    wr_item.coef_b = in_chan.osc_b_coef;
    wr_item.b_prev = in_chan.osc_b_start_prev;
    wr_item.b_cur  = in_chan.osc_b_start_cur;
    wr_item.mode   = in_chan.modulate_mode;
    wr_item.dur    = in_chan.duration_ms;
  end

  dtcg_item_mem #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_item_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IDX_W'(in_chan.item_index)),
    .wdata (wr_item),
    .re    (mem_re),
    .raddr (cur_item_r),
    .rdata (entry)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    ctl.mul_a      = (state_r == S_MA);
    ctl.load_start = !loaded_r;
    ctl.mul_b      = (state_r == S_MB);
    ctl.upd_b      = (state_r == S_MM);
    ctl.mul_mag    = (state_r == S_MP);
    ctl.mul_mod    = (state_r == S_MS);
  end

  dtcg_voice u_voice (
    .clk    (clk),
    .ctl    (ctl),
    .entry  (entry),
    .sample (voice_sample)
  );

  // ---------------------------------------------------------------- sequencer
  // result register must be free (or draining) before a tick completes
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (is_tick) begin
          state_nxt = halted_r ? S_FIN : S_MA;
        end
      end
      S_MA: state_nxt = S_MB;
      S_MB: state_nxt = S_MM;
      S_MM: state_nxt = entry.mode ? S_MP : S_FIN;
      S_MP: state_nxt = S_MS;
      S_MS: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- playback position
  always_comb begin
    next_ext = {1'b0, cur_item_r} + (IDX_W+1)'(1);
    list_end = (int'(next_ext) >= int'(item_count_r)) || (int'(next_ext) >= MAX_ITEMS);
    // negative or out-of-range repeat position stops playback
    rp_bad   = (int'(repeat_pos_r) < 0) || (int'(repeat_pos_r) >= MAX_ITEMS);
    if (!list_end) begin
      new_item = next_ext[IDX_W-1:0];
    end else if (rp_bad) begin
      new_item = cur_item_r;
    end else begin
      new_item = IDX_W'(repeat_pos_r);
    end
    cnt_inc = count_r + CNT_W'(1);
    thr     = CNT_W'(entry.dur) * CNT_W'(SAMPLES_PER_MS);
  end

  always_comb begin
    cur_item_nxt = cur_item_r;
    loaded_nxt   = loaded_r;
    halted_nxt   = halted_r;
    count_nxt    = count_r;

    if (is_restart) begin
      cur_item_nxt = '0;
      loaded_nxt   = 1'b0;
      halted_nxt   = 1'b0;
      count_nxt    = '0;
    end

    if (state_r == S_MA) begin
      loaded_nxt = 1'b1;
    end

    // zero duration plays the item forever and leaves the count alone
    if (fin_go && !halted_r && (entry.dur != '0)) begin
      if (cnt_inc >= thr) begin
        count_nxt    = '0;
        cur_item_nxt = new_item;
        if (list_end && rp_bad) begin
          halted_nxt = 1'b1;
        end
        // a repeat onto the same item keeps the running resonators
        if (new_item != cur_item_r) begin
          loaded_nxt = 1'b0;
        end
      end else begin
        count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_item_r   <= '0;
      loaded_r     <= 1'b0;
      halted_r     <= 1'b0;
      count_r      <= '0;
      item_count_r <= CFG_W'(1);
      repeat_pos_r <= -CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_item_r  <= cur_item_nxt;
      loaded_r    <= loaded_nxt;
      halted_r    <= halted_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ITEM_COUNT: item_count_r <= cfg_wdata;
          CFG_REPEAT_POS: repeat_pos_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_sample_r  <= halted_r ? '0 : voice_sample;
      out_item_r    <= IDX_IN_W'(cur_item_r);
      out_stopped_r <= halted_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample       = out_sample_r;
  assign out_chan.playing_item = out_item_r;
  assign out_chan.stopped      = out_stopped_r;

  // ---------------------------------------------------------------- checks
  `DTCG_ASSERT_IMP(a_item_in_range, 1'b1, int'(cur_item_r) < MAX_ITEMS)
  `DTCG_ASSERT_NXT(a_restart_clears, is_restart, !halted_r && !loaded_r && count_r == '0)
  `DTCG_ASSERT_NXT(a_halt_beat_zero, fin_go && halted_r, out_valid_r && out_stopped_r && out_sample_r == '0)
  `DTCG_ASSERT_IMP(a_step_after_read, state_r == S_MA, $past(mem_re))

endmodule

`default_nettype wire
